// File: design/fbc_pkg.sv
// Package for the 64-bit Feistel block cipher: payload and config types,
// register indexes and the round function. Used by every file in design/.
package fbc_pkg;

   localparam int HALF_WIDTH      = 32;
   localparam int KEY_WIDTH       = 64;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int KEY_ROT_STEP    = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CIPHER_KEY = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIRECTION  = 8'd1;

   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

   typedef struct packed {
      logic [HALF_WIDTH-1:0] left_in;
      logic [HALF_WIDTH-1:0] right_in;
   } req_type;

   typedef struct packed {
      logic [HALF_WIDTH-1:0] left_out;
      logic [HALF_WIDTH-1:0] right_out;
   } rsp_type;

   typedef struct packed {
      logic [HALF_WIDTH-1:0] left;
      logic [HALF_WIDTH-1:0] right;
   } stage_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] cipher_key;
      logic                 direction;
   } cfg_type;

   // Low half of the key rotated right by n (n in 0..63).
   function automatic logic [HALF_WIDTH-1:0] key_slice(input logic [KEY_WIDTH-1:0] key,
                                                      input logic [5:0] n);
      logic [2*KEY_WIDTH-1:0] twice;
      twice = {key, key};
      return twice[{1'b0, n} +: HALF_WIDTH];
   endfunction

   // Round function: rotl(v,9) ^ ~rotr(v,11) ^ low32(v*k).
   function automatic logic [HALF_WIDTH-1:0] mix(input logic [HALF_WIDTH-1:0] v,
                                                input logic [HALF_WIDTH-1:0] k);
      logic [HALF_WIDTH-1:0] rol9;
      logic [HALF_WIDTH-1:0] ror11;
      logic [HALF_WIDTH-1:0] prod;
      rol9  = {v[22:0], v[31:23]};
      ror11 = {v[10:0], v[31:11]};
      prod  = 32'(v * k);
      return rol9 ^ ~ror11 ^ prod;
   endfunction

endpackage

// File: design/fbc_csr.sv
// Configuration registers of the cipher: key and direction.
// Depends on fbc_pkg for register indexes and the config struct.
module fbc_csr
   import fbc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [KEY_WIDTH-1:0]       csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CIPHER_KEY: cfg_in.cipher_key = csr_wdata;
            CSR_DIRECTION:  cfg_in.direction  = csr_wdata[0];
            default:        cfg_in = cfg_ff;   // drop writes beyond the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/fbc_round.sv
// One pipeline stage: a single Feistel round and its stage register.
// Depends on fbc_pkg for the stage type and the round function.
module fbc_round
   import fbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  stage_type             in_data,
   input  logic [HALF_WIDTH-1:0] round_key,
   output logic                  out_valid,
   input  logic                  out_ready,
   output stage_type             out_data
);

   logic      valid_ff;
   logic      valid_in;
   stage_type data_ff;
   stage_type data_in;

   // A stage takes an item when empty or when its item moves on.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in      = in_ready ? in_valid : valid_ff;
      data_in.left  = in_data.right;
      data_in.right = in_data.left ^ mix(in_data.right, round_key);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(data_ff))
      else $error("stalled stage lost or changed its item");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> in_ready)
      else $error("empty stage refused an item");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff)
      else $error("accepted item vanished from stage");

endmodule

// File: design/feistel_block_cipher_64.sv
// 64-bit Feistel block cipher, ROUNDS rounds, one round per pipeline stage.
// Depends on fbc_pkg, fbc_csr and fbc_round.
//
// The block accepts one item per clock until a stalled rsp_ready has filled
// every stage: every round is its own register stage holding one 32x32
// multiplier, so throughput is one item per cycle while rsp_ready is high.
// When rsp_ready is low only the full stages at the tail hold; empty
// stages further up keep filling, so req_ready stays high until every stage
// is occupied. Decryption swaps the halves on entry and exit and runs the
// same rounds with the round keys in reverse order. Write cipher_key and
// direction only while no item is in flight.
module feistel_block_cipher_64
   import fbc_pkg::*;
#(
   parameter int ROUNDS = 16
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [KEY_WIDTH-1:0]       csr_wdata
);

   cfg_type   cfg;
   logic      stage_valid [0:ROUNDS];
   logic      stage_ready [0:ROUNDS];
   stage_type stage_data  [0:ROUNDS];

   fbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Swap halves on entry for decryption.
   assign stage_valid[0] = req_valid;
   assign req_ready      = stage_ready[0];
   assign stage_data[0]  = (cfg.direction == DIR_DECRYPT) ?
                           stage_type'{left: req_data.right_in, right: req_data.left_in} :
                           stage_type'{left: req_data.left_in,  right: req_data.right_in};

   for (genvar s = 0; s < ROUNDS; s++) begin : g_round
      localparam logic [5:0] ENC_ROT = 6'((KEY_ROT_STEP * s) % KEY_WIDTH);
      localparam logic [5:0] DEC_ROT = 6'((KEY_ROT_STEP * (ROUNDS - 1 - s)) % KEY_WIDTH);

      logic [HALF_WIDTH-1:0] round_key;

      assign round_key = (cfg.direction == DIR_DECRYPT) ?
                         key_slice(cfg.cipher_key, DEC_ROT) :
                         key_slice(cfg.cipher_key, ENC_ROT);

      fbc_round u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[s]),
         .in_ready  (stage_ready[s]),
         .in_data   (stage_data[s]),
         .round_key (round_key),
         .out_valid (stage_valid[s+1]),
         .out_ready (stage_ready[s+1]),
         .out_data  (stage_data[s+1])
      );
   end

   // Swap back on exit for decryption.
   assign rsp_valid           = stage_valid[ROUNDS];
   assign stage_ready[ROUNDS] = rsp_ready;
   assign rsp_data.left_out   = (cfg.direction == DIR_DECRYPT) ?
                                stage_data[ROUNDS].right : stage_data[ROUNDS].left;
   assign rsp_data.right_out  = (cfg.direction == DIR_DECRYPT) ?
                                stage_data[ROUNDS].left : stage_data[ROUNDS].right;

   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("pipeline refused an item while the output drained");

   a_empty_tail: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipeline refused an item with an empty output stage");

   a_key_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index == CSR_CIPHER_KEY
      |=> cfg.cipher_key == $past(csr_wdata))
      else $error("cipher key write not taken");

endmodule
